FILE: hw/rtl/chca_pkg.sv
// ----------------------------------------------------------------------------
// chca_pkg
// Shared types and constants for the canonical code assignment block:
// transaction structs, command codes, sequencer states and unit operations.
// ----------------------------------------------------------------------------
`default_nettype none

package chca_pkg;

    // Field widths of the transactions and of the length counts
    localparam int CODE_W = 64;
    localparam int LEN_W  = 7;
    localparam int SYM_W  = 8;
    localparam int CMD_W  = 2;
    localparam int CNT_W  = 9;

    // Parameter defaults
    localparam int SYMBOL_COUNT_DEF    = 256;
    localparam int MAX_CODE_LENGTH_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] length;
    } cmd_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic              status;
    } res_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_CNT_LEN,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_NC_RD,
        ST_NC_WR,
        ST_AS_LEN,
        ST_AS_RD,
        ST_AS_WR,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        ALU_NONE,
        ALU_INC_CNT,
        ALU_ACC,
        ALU_INC_NC
    } alu_op_t;

    // Control to the shared code unit
    typedef struct packed {
        alu_op_t          op;
        logic [LEN_W-1:0] len;
    } unit_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/chca_code_unit.sv
// ----------------------------------------------------------------------------
// chca_code_unit
// Shared 64-bit adder used by each build phase after the clear (count increment, code
// accumulation, next-code increment) and the bit reversal of a code over
// its length.
// ----------------------------------------------------------------------------
`default_nettype none

module chca_code_unit
    import chca_pkg::*;
(
    input  wire unit_ctl_t         ctl,
    input  wire logic [CODE_W-1:0] acc,
    input  wire logic [CNT_W-1:0]  cnt,
    input  wire logic [CODE_W-1:0] nc,
    output logic [CODE_W-1:0]      sum,
    output logic [CODE_W-1:0]      rev_code
);

    logic [CODE_W-1:0] op_a;
    logic [CODE_W-1:0] op_b;
    logic [CODE_W-1:0] rev_full;
    logic [5:0]        shamt;

    // Operand selection for the one adder
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (ctl.op)
            ALU_INC_CNT:
            begin
                op_a = CODE_W'(cnt);
                op_b = CODE_W'(1);
            end
            ALU_ACC:
            begin
                op_a = acc;
                op_b = CODE_W'(cnt);
            end
            ALU_INC_NC:
            begin
                op_a = nc;
                op_b = CODE_W'(1);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign sum = op_a + op_b;

    // Full reversal, then align the low len bits back to bit 0
    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
        begin
            rev_full[i] = nc[CODE_W-1-i];
        end
    end

    assign shamt    = 6'(7'd64 - ctl.len);
    assign rev_code = rev_full >> shamt;

endmodule

`default_nettype wire

FILE: hw/rtl/canonical_huffman_code_assign.sv
// ----------------------------------------------------------------------------
// canonical_huffman_code_assign
// Per-symbol code length store with canonical prefix code generation.
// ----------------------------------------------------------------------------
// A write or read transaction, and a no-op command, passes through the
// response state, which loads its result into the output register and
// returns to idle before the block accepts again, so each such transaction
// is finished before the next is taken; a result still held by a stalled
// receiver keeps the next one waiting in the response state. A build runs a
// sequencer over memories with one write port and one registered read port
// each and one shared adder: it clears the length counts, counts the lengths
// one symbol at a time, forms the first code of each length and assigns the
// codes one symbol at a time, and then loads its result. Codes read back are
// those of the last build, first-sent bit at bit 0; all codes read zero
// before the first build.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_huffman_code_assign
    import chca_pkg::*;
#(
    parameter int SYMBOL_COUNT    = SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd_item,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res_item
);

    localparam int SYM_IW = $clog2(SYMBOL_COUNT);
    localparam int LW     = $clog2(MAX_CODE_LENGTH + 1);
    localparam int LDEPTH = MAX_CODE_LENGTH + 1;

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    cmd_item_t          item_reg, item_next;
    logic [SYM_IW-1:0]  sym_cnt_reg, sym_cnt_next;
    logic [LW-1:0]      b_cnt_reg, b_cnt_next;
    logic [CODE_W-1:0]  acc_reg, acc_next;
    logic               built_reg, built_next;
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_item_reg, res_item_next;

    // Memories and their registered read data
    logic [LEN_W-1:0]        len_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] len_vld_reg;
    logic [CODE_W-1:0]       code_mem [SYMBOL_COUNT];
    logic [CNT_W-1:0]        cnt_mem [LDEPTH];
    logic [CODE_W-1:0]       nc_mem [LDEPTH];

    logic [LEN_W-1:0]  len_rd_reg;
    logic              len_vld_rd_reg;
    logic [CODE_W-1:0] code_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;
    logic [CODE_W-1:0] nc_rd_reg;

    // Memory port controls
    logic              accept;
    logic              sym_last;
    logic [SYM_IW-1:0] len_raddr;
    logic              len_we;
    logic [SYM_IW-1:0] code_raddr;
    logic              code_we;
    logic [CODE_W-1:0] code_wdata;
    logic [LW-1:0]     cnt_raddr;
    logic              cnt_we;
    logic [LW-1:0]     cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              nc_we;
    logic [LW-1:0]     nc_waddr;
    logic [CODE_W-1:0] nc_wdata;
    logic [LEN_W-1:0]  len_eff;
    logic [LW-1:0]     len_idx;
    logic              cmd_sym_ok;
    logic              item_sym_ok;

    // Shared unit
    unit_ctl_t         unit_ctl;
    logic [CODE_W-1:0] unit_sum;
    logic [CODE_W-1:0] unit_rev;

    chca_code_unit u_code_unit (
        .ctl      (unit_ctl),
        .acc      (acc_reg),
        .cnt      (cnt_rd_reg),
        .nc       (nc_rd_reg),
        .sum      (unit_sum),
        .rev_code (unit_rev)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    assign sym_last    = (sym_cnt_reg == SYM_IW'(SYMBOL_COUNT - 1));
    assign cmd_sym_ok  = (9'(cmd_item.symbol) < 9'(SYMBOL_COUNT));
    assign item_sym_ok = (9'(item_reg.symbol) < 9'(SYMBOL_COUNT));
    assign len_eff     = len_vld_rd_reg ? len_rd_reg : '0;
    assign len_idx     = len_eff[LW-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_t'(cmd_item.cmd) == CMD_BUILD)
                        state_next = ST_CLR;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_CLR:
            begin
                if (b_cnt_reg == LW'(MAX_CODE_LENGTH))
                    state_next = ST_CNT_LEN;
            end
            ST_CNT_LEN: state_next = ST_CNT_RD;
            ST_CNT_RD:  state_next = ST_CNT_WR;
            ST_CNT_WR:  state_next = sym_last ? ST_NC_RD : ST_CNT_LEN;
            ST_NC_RD:   state_next = ST_NC_WR;
            ST_NC_WR:
            begin
                if (b_cnt_reg == LW'(MAX_CODE_LENGTH))
                    state_next = ST_AS_LEN;
                else
                    state_next = ST_NC_RD;
            end
            ST_AS_LEN:  state_next = ST_AS_RD;
            ST_AS_RD:   state_next = ST_AS_WR;
            ST_AS_WR:   state_next = sym_last ? ST_RESP : ST_AS_LEN;
            ST_RESP:
            begin
                if (!res_valid_reg || !res_stall)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory port and unit controls
    always_comb
    begin
        // read ports hold the accepted symbol while its result waits
        len_raddr  = sym_cnt_reg;
        code_raddr = item_reg.symbol[SYM_IW-1:0];
        if (state_reg == ST_IDLE)
        begin
            len_raddr  = cmd_item.symbol[SYM_IW-1:0];
            code_raddr = cmd_item.symbol[SYM_IW-1:0];
        end
        else if (state_reg == ST_RESP)
            len_raddr = item_reg.symbol[SYM_IW-1:0];
        len_we     = accept && (cmd_t'(cmd_item.cmd) == CMD_WRITE)
                     && (cmd_item.length <= LEN_W'(MAX_CODE_LENGTH)) && cmd_sym_ok;
        code_we    = 1'b0;
        code_wdata = '0;
        cnt_raddr  = (state_reg == ST_NC_RD) ? (b_cnt_reg - LW'(1)) : len_idx;
        cnt_we     = 1'b0;
        cnt_waddr  = b_cnt_reg;
        cnt_wdata  = '0;
        nc_we      = 1'b0;
        nc_waddr   = b_cnt_reg;
        nc_wdata   = '0;
        unit_ctl   = '{op: ALU_NONE, len: len_eff};
        unique case (state_reg)
            ST_CLR:
            begin
                cnt_we = 1'b1;
            end
            ST_CNT_WR:
            begin
                unit_ctl.op = ALU_INC_CNT;
                cnt_we      = (len_eff != '0);
                cnt_waddr   = len_idx;
                cnt_wdata   = unit_sum[CNT_W-1:0];
            end
            ST_NC_WR:
            begin
                unit_ctl.op = ALU_ACC;
                nc_we       = 1'b1;
                nc_wdata    = {unit_sum[CODE_W-2:0], 1'b0};
            end
            ST_AS_WR:
            begin
                unit_ctl.op = ALU_INC_NC;
                nc_we       = (len_eff != '0);
                nc_waddr    = len_idx;
                nc_wdata    = unit_sum;
                code_we     = 1'b1;
                code_wdata  = (len_eff != '0) ? unit_rev : '0;
            end
            default:
            begin
                unit_ctl.op = ALU_NONE;
            end
        endcase
    end

    // Counters, accumulator and result
    always_comb
    begin
        item_next      = item_reg;
        sym_cnt_next   = sym_cnt_reg;
        b_cnt_next     = b_cnt_reg;
        acc_next       = acc_reg;
        built_next     = built_reg;
        res_item_next  = res_item_reg;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next    = cmd_item;
                    sym_cnt_next = '0;
                    b_cnt_next   = '0;
                    acc_next     = '0;
                end
            end
            ST_CLR:
            begin
                if (b_cnt_reg == LW'(MAX_CODE_LENGTH))
                    b_cnt_next = LW'(1);
                else
                    b_cnt_next = b_cnt_reg + LW'(1);
            end
            ST_CNT_WR, ST_AS_WR:
            begin
                sym_cnt_next = sym_last ? '0 : (sym_cnt_reg + SYM_IW'(1));
                if (state_reg == ST_AS_WR && sym_last)
                    built_next = 1'b1;
            end
            ST_NC_WR:
            begin
                acc_next   = {unit_sum[CODE_W-2:0], 1'b0};
                b_cnt_next = b_cnt_reg + LW'(1);
            end
            ST_RESP:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = '0;
                    case (cmd_t'(item_reg.cmd))
                        CMD_WRITE:
                            res_item_next.status =
                                (item_reg.length > LEN_W'(MAX_CODE_LENGTH));
                        CMD_READ:
                        begin
                            if (item_sym_ok)
                            begin
                                res_item_next.code_bits   = built_reg ? code_rd_reg : '0;
                                res_item_next.code_length = len_eff;
                            end
                        end
                        default:
                            res_item_next = '0;
                    endcase
                end
            end
            default:
            begin
                sym_cnt_next = sym_cnt_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sym_cnt_reg   <= '0;
            b_cnt_reg     <= '0;
            built_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            len_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sym_cnt_reg   <= sym_cnt_next;
            b_cnt_reg     <= b_cnt_next;
            built_reg     <= built_next;
            res_valid_reg <= res_valid_next;
            if (len_we)
                len_vld_reg[cmd_item.symbol[SYM_IW-1:0]] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        acc_reg      <= acc_next;
        res_item_reg <= res_item_next;
    end

    // Length store
    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[cmd_item.symbol[SYM_IW-1:0]] <= cmd_item.length;
        len_rd_reg     <= len_mem[len_raddr];
        len_vld_rd_reg <= len_vld_reg[len_raddr];
    end

    // Code store
    always_ff @(posedge clk)
    begin
        if (code_we)
            code_mem[sym_cnt_reg] <= code_wdata;
        code_rd_reg <= code_mem[code_raddr];
    end

    // Length count store
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    // Next code per length store
    always_ff @(posedge clk)
    begin
        if (nc_we)
            nc_mem[nc_waddr] <= nc_wdata;
        nc_rd_reg <= nc_mem[len_idx];
    end

    // Checks
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted transaction did not start work");

    a_built_after_assign: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(built_reg) |-> $past(state_reg) == ST_AS_WR)
        else $error("code table marked built outside the assign phase");

    a_reject_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status |-> res_item.code_bits == '0
                                         && res_item.code_length == '0)
        else $error("rejected write carries code data");

    a_nc_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NC_RD |-> b_cnt_reg != '0)
        else $error("first-code pass reached length zero");

endmodule

`default_nettype wire
